/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define UNP_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define UNP_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

/* sv/unp_pkg.sv */
// ----------------------------------------------------------------------------
// unp_pkg
// Types, constants and the division step shared by the unpremultiply pipe.
// ----------------------------------------------------------------------------
package unp_pkg;

    localparam int BYTE_W     = 8;
    localparam int NUM_LANES  = 3;                 // red, green, blue
    localparam int NUM_W      = 2 * BYTE_W;        // c*255 + a/2 fits in 16 bits
    localparam int ALPHA_LSB  = 24;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES = BYTE_W / BITS_PER_STAGE;
    localparam logic [BYTE_W-1:0] FULL_SCALE = 8'hff;

    typedef struct packed {
        logic [NUM_W-1:0]  rem;      // partial remainder
        logic [BYTE_W-1:0] quo;      // quotient bits found so far
        logic              ovr;      // result forced (zero alpha or saturation)
        logic [BYTE_W-1:0] ovr_val;
    } t_lane;

    typedef struct packed {
        t_lane [NUM_LANES-1:0] lane;
        logic  [BYTE_W-1:0]    alpha;
    } t_work;

    // One restoring division step for quotient bit b.
    function automatic t_lane f_div_step(t_lane l, logic [BYTE_W-1:0] a, logic [2:0] b);
        t_lane             r;
        logic [NUM_W-1:0]  trial;
        r     = l;
        trial = NUM_W'(a) << b;
        if (l.rem >= trial) begin
            r.rem    = l.rem - trial;
            r.quo[b] = 1'b1;
        end
        return r;
    endfunction

endpackage

/* sv/argb_unpremultiply_top.sv */
// ----------------------------------------------------------------------------
// argb_unpremultiply_top
// Premultiplied ARGB32 to straight-alpha bytes, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one pixel request per clock and gives one result per clock while the
// output is not stalled. Six register stages: one that forms c*255 + a/2 and
// flags zero alpha and saturation (loaded at the accepting edge), four radix-4
// restoring division stages (two quotient bits each, three color lanes side by
// side) and the output register.
// Each stage holds its item under i_stall and takes a new one as soon as it is
// empty or its item moves on, so bubbles close up while the output is stalled.
`include "assert_macros.svh"

module argb_unpremultiply_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_pixel_argb,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_opacity
);
    import unp_pkg::*;

    logic  w_valid [DIV_STAGES+1];
    logic  w_stall [DIV_STAGES+1];
    t_work w_work  [DIV_STAGES+1];

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_red;
    logic [BYTE_W-1:0] r_green;
    logic [BYTE_W-1:0] r_blue;
    logic [BYTE_W-1:0] r_opacity;
    logic              w_out_stall;
    logic              w_out_load;

    unp_prep u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_pixel_argb (i_pixel_argb),
        .o_valid      (w_valid[0]),
        .i_stall      (w_stall[0]),
        .o_work       (w_work[0])
    );

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        unp_div_stage #(
            .HI_BIT (BYTE_W - 1 - BITS_PER_STAGE * s)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[s]),
            .o_stall (w_stall[s]),
            .i_work  (w_work[s]),
            .o_valid (w_valid[s+1]),
            .i_stall (w_stall[s+1]),
            .o_work  (w_work[s+1])
        );
    end

    assign w_out_stall         = r_out_valid && i_stall;
    assign w_stall[DIV_STAGES] = w_out_stall;
    assign w_out_load          = !w_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= w_valid[DIV_STAGES];
        end
    end

    // forced value wins over the quotient for zero alpha and saturation
    always_ff @(posedge i_clk) begin
        if (w_out_load && w_valid[DIV_STAGES]) begin
            r_red     <= w_work[DIV_STAGES].lane[2].ovr ? w_work[DIV_STAGES].lane[2].ovr_val
                                                        : w_work[DIV_STAGES].lane[2].quo;
            r_green   <= w_work[DIV_STAGES].lane[1].ovr ? w_work[DIV_STAGES].lane[1].ovr_val
                                                        : w_work[DIV_STAGES].lane[1].quo;
            r_blue    <= w_work[DIV_STAGES].lane[0].ovr ? w_work[DIV_STAGES].lane[0].ovr_val
                                                        : w_work[DIV_STAGES].lane[0].quo;
            r_opacity <= w_work[DIV_STAGES].alpha;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_red     = r_red;
    assign o_green   = r_green;
    assign o_blue    = r_blue;
    assign o_opacity = r_opacity;

    `UNP_IMPLY(a_zero_alpha_out, o_valid && o_opacity == '0,
        o_red == '0 && o_green == '0 && o_blue == '0,
        "zero alpha result has nonzero color")
    `UNP_IMPLY(a_stall_source, o_stall, i_stall,
        "input stalled without output back pressure")

endmodule

/* sv/unp_prep.sv */
// ----------------------------------------------------------------------------
// unp_prep
// Unpacks the pixel, forms the rounded numerators and flags forced results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module unp_prep (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [31:0]      i_pixel_argb,
    output logic             o_valid,
    input  logic             i_stall,
    output unp_pkg::t_work   o_work
);
    import unp_pkg::*;

    logic  r_valid;
    t_work r_work;
    t_work n_work;
    logic  w_load;

    assign o_stall = r_valid && i_stall;
    assign w_load  = !o_stall;

    always_comb begin
        logic [BYTE_W-1:0] c;
        logic [NUM_W-1:0]  num;
        n_work.alpha = i_pixel_argb[ALPHA_LSB +: BYTE_W];
        for (int l = 0; l < NUM_LANES; l++) begin
            // lane 0 is blue, lane 2 is red
            c   = i_pixel_argb[l*BYTE_W +: BYTE_W];
            // c*255 as (c<<8) - c, plus a/2 for round to nearest
            num = (NUM_W'(c) << BYTE_W) - NUM_W'(c) + NUM_W'(n_work.alpha[BYTE_W-1:1]);
            n_work.lane[l].rem = num;
            n_work.lane[l].quo = '0;
            if (n_work.alpha == '0) begin
                n_work.lane[l].ovr     = 1'b1;
                n_work.lane[l].ovr_val = '0;
            end else if (num >= (NUM_W'(n_work.alpha) << BYTE_W)) begin
                // quotient would exceed 255
                n_work.lane[l].ovr     = 1'b1;
                n_work.lane[l].ovr_val = FULL_SCALE;
            end else begin
                n_work.lane[l].ovr     = 1'b0;
                n_work.lane[l].ovr_val = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_valid) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

    `UNP_IMPLY(a_zero_alpha_forced, r_valid && r_work.alpha == '0,
        r_work.lane[0].ovr && r_work.lane[0].ovr_val == '0,
        "zero alpha request not forced to zero")

endmodule

/* sv/unp_div_stage.sv */
// ----------------------------------------------------------------------------
// unp_div_stage
// Two restoring division steps per lane, one register stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module unp_div_stage #(
    parameter int HI_BIT = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  unp_pkg::t_work   i_work,
    output logic             o_valid,
    input  logic             i_stall,
    output unp_pkg::t_work   o_work
);
    import unp_pkg::*;

    localparam int LO_BIT = HI_BIT - 1;

    logic  r_valid;
    t_work r_work;
    t_work n_work;
    logic  w_load;

    assign o_stall = r_valid && i_stall;
    assign w_load  = !o_stall;

    always_comb begin
        n_work = i_work;
        for (int l = 0; l < NUM_LANES; l++) begin
            n_work.lane[l] = f_div_step(
                f_div_step(i_work.lane[l], i_work.alpha, 3'(HI_BIT)),
                i_work.alpha, 3'(LO_BIT));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_valid) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

    // remainder must stay below the divisor at the current bit weight
    `UNP_IMPLY(a_rem_red, r_valid && !r_work.lane[2].ovr,
        r_work.lane[2].rem < (NUM_W'(r_work.alpha) << LO_BIT),
        "red remainder out of range")
    `UNP_IMPLY(a_rem_green, r_valid && !r_work.lane[1].ovr,
        r_work.lane[1].rem < (NUM_W'(r_work.alpha) << LO_BIT),
        "green remainder out of range")
    `UNP_IMPLY(a_rem_blue, r_valid && !r_work.lane[0].ovr,
        r_work.lane[0].rem < (NUM_W'(r_work.alpha) << LO_BIT),
        "blue remainder out of range")

endmodule
